[rtl/core/assert_macros.svh]
// Assertion helpers shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FFBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FFBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ffba_pkg.sv]
`default_nettype none

package ffba_pkg;

  localparam int OPCODE_W = 2;
  localparam int BYTES_W  = 32;
  localparam int OFFSET_W = 18;

  localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RESIZE  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [BYTES_W-1:0]  request_bytes;
    logic [OFFSET_W-1:0] payload_offset;
    logic                pointer_is_null;
  } req_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] result_offset;
    logic                result_is_null;
  } rsp_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_AWALK,
    S_AWRITE,
    S_FWALK,
    S_RHEAD,
    S_RMERGE,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

[rtl/core/first_fit_block_allocator_core.sv]
// Operation: an accept, then a walk over the block headers for the first-fit or
// lookup walk, a merge of following free neighbors on release, the header writes,
// and a load of the result register.
// Throughput: one request at a time; the header memory walk sets the rate.
// Reset: synchronous, active high; after reset the S_INIT state writes the whole-arena free
// header at granule 0 while req_stall is high.
`default_nettype none

`include "assert_macros.svh"

module first_fit_block_allocator_core #(
  parameter int ARENA_GRANULES = 16384
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire ffba_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output ffba_pkg::rsp_t       rsp
);
  import ffba_pkg::*;

  localparam int GW = $clog2(ARENA_GRANULES);
  localparam int SW = $clog2(ARENA_GRANULES + 1);
  localparam int HW = SW + 1;
  localparam logic [SW-1:0] ARENA_S = SW'(ARENA_GRANULES);
  localparam logic [SW:0]   ARENA_W = (SW+1)'(ARENA_GRANULES);

  // Header memory: {size in granules, used}.
  logic [HW-1:0] mem [ARENA_GRANULES];
  logic [HW-1:0] rd_data;
  logic [GW-1:0] rd_addr;
  logic [GW-1:0] wr_addr;
  logic [HW-1:0] wr_data;
  logic          we;

  state_t state, state_next;

  logic [OPCODE_W-1:0] op_r;
  logic                zero_r;
  logic                too_big_r;
  logic [SW-1:0]       need_r;
  logic [13:0]         target_r;

  logic [SW-1:0] g, g_next;
  logic [SW-1:0] fg, fg_next;
  logic [SW-1:0] nx, nx_next;
  logic [SW-1:0] rel_s, rel_s_next;
  logic [SW-1:0] alloc_size, alloc_size_next;
  logic [SW-1:0] res_g, res_g_next;
  logic          res_ok, res_ok_next;
  logic          rsp_load;

  logic          accept;
  logic [32:0]   bytes_round;
  logic [29:0]   need_full;
  logic          req_zero;
  logic          req_too_big;
  logic          off_bad;

  logic [SW-1:0] hs;
  logic          hu;
  logic [SW:0]   walk_sum;
  logic [SW:0]   head_sum;
  logic [SW:0]   merge_s;
  logic [SW:0]   merge_sum;
  logic [SW:0]   split_min;
  logic [SW:0]   split_at;
  logic [13:0]   pay_gran;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  // need = ceil(bytes / 16) + 1, kept wide so oversized requests cannot wrap.
  assign bytes_round = {1'b0, req.request_bytes} + 33'd15;
  assign need_full   = 30'(bytes_round[32:4]) + 30'd1;
  assign req_zero    = (req.request_bytes == '0);
  assign req_too_big = (need_full > 30'(ARENA_GRANULES));
  assign off_bad     = (req.payload_offset[17:4] == '0) || (req.payload_offset[3:0] != '0);

  assign hs        = rd_data[HW-1:1];
  assign hu        = rd_data[0];
  assign walk_sum  = {1'b0, g} + {1'b0, hs};
  assign head_sum  = {1'b0, fg} + {1'b0, hs};
  assign merge_s   = {1'b0, rel_s} + {1'b0, hs};
  assign merge_sum = {1'b0, fg} + merge_s;
  assign split_min = {1'b0, need_r} + (SW+1)'(2);
  assign split_at  = {1'b0, g} + {1'b0, need_r};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    g          <= g_next;
    fg         <= fg_next;
    nx         <= nx_next;
    rel_s      <= rel_s_next;
    alloc_size <= alloc_size_next;
    res_g      <= res_g_next;
    res_ok     <= res_ok_next;
    if (accept) begin
      // A resize of a null pointer is an allocate.
      op_r      <= (req.opcode == OP_RESIZE && req.pointer_is_null) ? OP_ALLOC : req.opcode;
      zero_r    <= req_zero;
      too_big_r <= req_too_big;
      need_r    <= need_full[SW-1:0];
      target_r  <= req.payload_offset[17:4] - 14'd1;
    end
  end

  assign pay_gran = 14'(res_g) + 14'd1;

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.result_is_null <= !res_ok;
      rsp.result_offset  <= res_ok ? {pay_gran, 4'b0000} : '0;
    end
  end

  always_comb begin
    state_next      = state;
    g_next          = g;
    fg_next         = fg;
    nx_next         = nx;
    rel_s_next      = rel_s;
    alloc_size_next = alloc_size;
    res_g_next      = res_g;
    res_ok_next     = res_ok;
    rd_addr         = g[GW-1:0];
    we              = 1'b0;
    wr_addr         = fg[GW-1:0];
    wr_data         = '0;
    rsp_load        = 1'b0;

    unique case (state)
      S_INIT: begin
        we         = 1'b1;
        wr_addr    = '0;
        wr_data    = {ARENA_S, 1'b0};
        state_next = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          g_next      = '0;
          rd_addr     = '0;
          res_ok_next = 1'b0;
          priority if (req.opcode == OP_ALLOC ||
                       (req.opcode == OP_RESIZE && req.pointer_is_null)) begin
            state_next = (req_zero || req_too_big) ? S_RESP : S_AWALK;
          end else if (req.opcode == OP_RELEASE) begin
            state_next = (req.pointer_is_null || off_bad) ? S_RESP : S_FWALK;
          end else if (req.opcode == OP_RESIZE) begin
            state_next = off_bad ? S_RESP : S_FWALK;
          end else begin
            state_next = S_RESP;
          end
        end
      end

      S_AWALK: begin
        if (hs == '0) begin
          res_ok_next = 1'b0;
          state_next  = S_RESP;
        end else if (!hu && hs >= need_r) begin
          if ({1'b0, hs} >= split_min) begin
            we              = 1'b1;
            wr_addr         = split_at[GW-1:0];
            wr_data         = {hs - need_r, 1'b0};
            alloc_size_next = need_r;
          end else begin
            alloc_size_next = hs;
          end
          state_next = S_AWRITE;
        end else if (walk_sum >= ARENA_W) begin
          res_ok_next = 1'b0;
          state_next  = S_RESP;
        end else begin
          g_next  = walk_sum[SW-1:0];
          rd_addr = walk_sum[GW-1:0];
        end
      end

      S_AWRITE: begin
        we          = 1'b1;
        wr_addr     = g[GW-1:0];
        wr_data     = {alloc_size, 1'b1};
        res_ok_next = 1'b1;
        res_g_next  = g;
        if (op_r == OP_RESIZE) begin
          // The old block is released only after the new one is in place.
          rd_addr    = fg[GW-1:0];
          state_next = S_RHEAD;
        end else begin
          state_next = S_RESP;
        end
      end

      S_FWALK: begin
        if (18'(g) == 18'(target_r)) begin
          fg_next = g;
          if (op_r == OP_RELEASE || zero_r) begin
            res_ok_next = 1'b0;
            state_next  = S_RHEAD;
          end else if (too_big_r) begin
            // A size beyond the arena neither fits in place nor can be allocated.
            res_ok_next = 1'b0;
            state_next  = S_RESP;
          end else if (hs >= need_r) begin
            res_ok_next = 1'b1;
            res_g_next  = g;
            state_next  = S_RESP;
          end else begin
            g_next     = '0;
            rd_addr    = '0;
            state_next = S_AWALK;
          end
        end else if (18'(g) > 18'(target_r) || hs == '0 || walk_sum >= ARENA_W) begin
          res_ok_next = 1'b0;
          state_next  = S_RESP;
        end else begin
          g_next  = walk_sum[SW-1:0];
          rd_addr = walk_sum[GW-1:0];
        end
      end

      S_RHEAD: begin
        if (head_sum >= ARENA_W) begin
          we         = 1'b1;
          wr_data    = {hs, 1'b0};
          state_next = S_RESP;
        end else begin
          rel_s_next = hs;
          nx_next    = head_sum[SW-1:0];
          rd_addr    = head_sum[GW-1:0];
          state_next = S_RMERGE;
        end
      end

      S_RMERGE: begin
        if (hu || hs == '0) begin
          we         = 1'b1;
          wr_data    = {rel_s, 1'b0};
          state_next = S_RESP;
        end else if (merge_sum >= ARENA_W) begin
          we         = 1'b1;
          wr_data    = {merge_s[SW-1:0], 1'b0};
          state_next = S_RESP;
        end else begin
          rel_s_next = merge_s[SW-1:0];
          nx_next    = merge_sum[SW-1:0];
          rd_addr    = merge_sum[GW-1:0];
        end
      end

      S_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `FFBA_ASSERT(a_walk_in_arena, (state == S_AWALK || state == S_FWALK) |-> g < ARENA_S, "walk pointer left the arena")
  `FFBA_ASSERT(a_merge_ahead, (state == S_RMERGE) |-> (nx > fg && nx < ARENA_S), "merge pointer not after released block")
  `FFBA_ASSERT(a_null_offset, (rsp_valid && rsp.result_is_null) |-> rsp.result_offset == '0, "null result with nonzero offset")
  `FFBA_ASSERT_ALWAYS(a_reset_init, rst |=> state == S_INIT, "reset did not enter header init")

endmodule

`default_nettype wire
